@@ sv/jff_pkg.sv @@
// Shared types, constants and fixed-point helpers for the joint feedback filter.
// Used by the sequencer, the datapath and the top level; depends on nothing.

package jff_pkg;

    // Microprogram address width and a few fixed addresses.
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_IDLE  = t_step'(0);
    localparam t_step STEP_FIRST = t_step'(1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_COUNT    = 3'd0,
        REG_DIRECTION     = 3'd1,
        REG_POS_SCALE     = 3'd2,
        REG_VEL_SCALE     = 3'd3,
        REG_RATED_CURRENT = 3'd4,
        REG_CONTROL_RATE  = 3'd5,
        REG_WRIST_MODE    = 3'd6
    } t_reg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic [31:0] zero_count;
        logic        direction;
        logic [31:0] pos_scale;
        logic [31:0] vel_scale;
        logic [23:0] rated_current;
        logic [7:0]  control_rate;
        logic        wrist_mode;
    } t_cfg;

    // Multiplier operand loads.
    typedef enum logic [3:0] {
        LD_HOLD,
        LD_POS,
        LD_VEL,
        LD_CUR,
        LD_FV_OLD,
        LD_FV_NEW,
        LD_DIV,
        LD_QK,
        LD_FC_OLD,
        LD_FC_NEW,
        LD_AIN,
        LD_FA_OLD,
        LD_FA_NEW
    } t_ld;

    // Datapath operations on the product and accumulator.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ANG_RND,
        OP_VNEW,
        OP_CUR_MAG,
        OP_ACC_LD,
        OP_ACC_ADD,
        OP_Q0,
        OP_FV,
        OP_WRAP,
        OP_REM,
        OP_CNEW,
        OP_FC,
        OP_AIN,
        OP_FA,
        OP_DONE
    } t_op;

    // Sequencer branch conditions.
    typedef enum logic [1:0] {
        C_NEXT,
        C_IN,
        C_OUT
    } t_cond;

    // One microprogram word.
    typedef struct packed {
        t_cond cond;
        t_step target;
        t_ld   ld;
        t_op   op;
    } t_uword;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        t_ld ld;
        t_op op;
    } t_ctl;

    // Q16 constants.
    localparam logic signed [49:0] PI_Q16     = 50'sd205887;
    localparam logic signed [49:0] TWO_PI_Q16 = 50'sd411775;
    localparam logic signed [31:0] DEADBAND_Q16 = 32'sd328;
    localparam logic signed [32:0] W_FAST_OLD = 33'sd52429;
    localparam logic signed [32:0] W_FAST_NEW = 33'sd13107;
    localparam logic signed [32:0] W_SLOW_OLD = 33'sd64881;
    localparam logic signed [32:0] W_SLOW_NEW = 33'sd655;
    localparam logic signed [32:0] W_CUR_OLD  = 33'sd58982;
    localparam logic signed [32:0] W_CUR_NEW  = 33'sd6554;

    // Divide by 1000: estimate with floor(2^32 * 256 / 1000), then fix up.
    localparam logic signed [32:0] DIV1000_RECIP = 33'sd1099511627;
    localparam logic signed [32:0] K_THOUSAND    = 33'sd1000;
    localparam logic [39:0]        ROUND_HALF_K  = 40'd500;

    // Divide by 2^16, rounding half away from zero.
    function automatic logic signed [49:0] f_rnd16(input logic signed [65:0] x);
        logic signed [65:0] s;
        s = x + (x[65] ? 66'sd32767 : 66'sd32768);
        return s[65:16];
    endfunction

    // Saturate to 32 bits signed.
    function automatic logic signed [31:0] f_sat50(input logic signed [49:0] x);
        logic signed [31:0] y;
        if (x > 50'sd2147483647) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -50'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

@@ sv/jff_seq.sv @@
// Microprogram sequencer: step counter, program ROM and conditional branches.
// Depends on jff_pkg for the microword and control types.

module jff_seq import jff_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_accept,
    input  logic i_out_free,
    output logic o_idle,
    output t_ctl o_ctl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    logic   w_fire;

    // Program ROM. Each step selects a multiplier operand load (or a hold) and one operation.
    // A load's operands are registered, then their product is registered, before an operation uses it.
    always_comb begin
        w_uw = '{cond: C_NEXT, target: STEP_IDLE, ld: LD_HOLD, op: OP_NOP};
        unique case (r_step)
            5'd0:  w_uw = '{cond: C_IN,   target: STEP_FIRST, ld: LD_HOLD,   op: OP_NOP};
            5'd1:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_POS,    op: OP_NOP};
            5'd2:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_VEL,    op: OP_NOP};
            5'd3:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_CUR,    op: OP_ANG_RND};
            5'd4:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_FV_OLD, op: OP_VNEW};
            5'd5:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_FV_NEW, op: OP_CUR_MAG};
            5'd6:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_DIV,    op: OP_ACC_LD};
            5'd7:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_ACC_ADD};
            5'd8:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_Q0};
            5'd9:  w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_QK,     op: OP_FV};
            5'd10: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_FC_OLD, op: OP_WRAP};
            5'd11: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_REM};
            5'd12: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_ACC_LD};
            5'd13: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_CNEW};
            5'd14: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_FC_NEW, op: OP_NOP};
            5'd15: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_AIN,    op: OP_NOP};
            5'd16: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_ACC_ADD};
            5'd17: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_FA_OLD, op: OP_FC};
            5'd18: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_AIN};
            5'd19: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_FA_NEW, op: OP_ACC_LD};
            5'd20: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_NOP};
            5'd21: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_ACC_ADD};
            5'd22: w_uw = '{cond: C_NEXT, target: STEP_IDLE,  ld: LD_HOLD,   op: OP_FA};
            5'd23: w_uw = '{cond: C_OUT,  target: STEP_IDLE,  ld: LD_HOLD,   op: OP_DONE};
            default: w_uw = '{cond: C_NEXT, target: STEP_IDLE, ld: LD_HOLD, op: OP_NOP};
        endcase
    end

    // A waiting step fires only once its condition is met.
    always_comb begin
        unique case (w_uw.cond)
            C_NEXT:  w_fire = 1'b1;
            C_IN:    w_fire = i_in_accept;
            C_OUT:   w_fire = i_out_free;
            default: w_fire = 1'b0;
        endcase
    end

    // Next step: fall through, or branch to the target once a wait is over.
    always_comb begin
        if (w_uw.cond == C_NEXT) begin
            n_step = r_step + t_step'(1);
        end else if (w_fire) begin
            n_step = w_uw.target;
        end else begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Control outputs; a waiting step issues nothing.
    assign o_ctl.ld = w_fire ? w_uw.ld : LD_HOLD;
    assign o_ctl.op = w_fire ? w_uw.op : OP_NOP;
    assign o_idle   = (r_step == STEP_IDLE);

endmodule

@@ sv/jff_dp.sv @@
// Datapath: input latches, one shared registered multiplier, accumulator,
// filter state and the intermediate results. Depends on jff_pkg.

module jff_dp import jff_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  t_cfg               i_cfg,
    input  logic               i_load,
    input  logic signed [31:0] i_raw_position,
    input  logic signed [31:0] i_raw_velocity,
    input  logic signed [15:0] i_raw_current,
    output logic signed [31:0] o_angle,
    output logic signed [31:0] o_speed,
    output logic signed [31:0] o_amps,
    output logic signed [31:0] o_accel
);

    // Latched input beat.
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [15:0] r_cur;

    // Multiplier operands and product.
    logic signed [32:0] r_ma;
    logic signed [32:0] r_mb;
    logic signed [32:0] n_ma;
    logic signed [32:0] n_mb;
    logic signed [65:0] r_prod;

    // Accumulator and intermediates.
    logic signed [48:0] r_acc;
    logic signed [49:0] r_ang;
    logic signed [31:0] r_angle;
    logic signed [31:0] r_vnew;
    logic [39:0]        r_x;
    logic               r_cneg;
    logic [30:0]        r_q;
    logic [11:0]        r_rem;
    logic signed [31:0] r_cnew;
    logic signed [31:0] r_ain;
    logic signed [31:0] r_fvn;

    // Filter state.
    logic signed [31:0] r_fv;
    logic signed [31:0] r_fc;
    logic signed [31:0] r_fa;

    // Helper values.
    logic signed [32:0] w_pos33;
    logic signed [32:0] w_off33;
    logic signed [32:0] w_vel33;
    logic signed [32:0] w_cur33;
    logic signed [65:0] w_acc66;
    logic signed [49:0] w_wrap;
    logic               w_dead;
    logic [39:0]        w_pmag;
    logic [1:0]         w_corr;
    logic [31:0]        w_qe;
    logic [31:0]        w_addend;

    assign w_pos33 = {r_pos[31], r_pos};
    assign w_off33 = {i_cfg.zero_count[31], i_cfg.zero_count};
    assign w_vel33 = {r_vel[31], r_vel};
    assign w_cur33 = {{17{r_cur[15]}}, r_cur};
    assign w_acc66 = {{17{r_acc[48]}}, r_acc};

    // Operand selection for the next multiply; the sign of the joint is
    // folded into the operand so that rounding stays symmetric.
    always_comb begin
        n_ma = r_ma;
        n_mb = r_mb;
        unique case (i_ctl.ld)
            LD_HOLD: begin
                n_ma = r_ma;
                n_mb = r_mb;
            end
            LD_POS: begin
                n_ma = i_cfg.direction ? (w_off33 - w_pos33) : (w_pos33 - w_off33);
                n_mb = {1'b0, i_cfg.pos_scale};
            end
            LD_VEL: begin
                n_ma = i_cfg.direction ? (33'sd0 - w_vel33) : w_vel33;
                n_mb = {1'b0, i_cfg.vel_scale};
            end
            LD_CUR: begin
                n_ma = i_cfg.direction ? (33'sd0 - w_cur33) : w_cur33;
                n_mb = {9'b0, i_cfg.rated_current};
            end
            LD_FV_OLD: begin
                n_ma = {r_fv[31], r_fv};
                n_mb = i_cfg.wrist_mode ? W_SLOW_OLD : W_FAST_OLD;
            end
            LD_FV_NEW: begin
                n_ma = {r_vnew[31], r_vnew};
                n_mb = i_cfg.wrist_mode ? W_SLOW_NEW : W_FAST_NEW;
            end
            LD_DIV: begin
                n_ma = {1'b0, r_x[39:8]};
                n_mb = DIV1000_RECIP;
            end
            LD_QK: begin
                n_ma = {2'b0, r_q};
                n_mb = K_THOUSAND;
            end
            LD_FC_OLD: begin
                n_ma = {r_fc[31], r_fc};
                n_mb = W_CUR_OLD;
            end
            LD_FC_NEW: begin
                n_ma = {r_cnew[31], r_cnew};
                n_mb = W_CUR_NEW;
            end
            LD_AIN: begin
                n_ma = {r_fvn[31], r_fvn} - {r_fv[31], r_fv};
                n_mb = {25'b0, i_cfg.control_rate};
            end
            LD_FA_OLD: begin
                n_ma = {r_fa[31], r_fa};
                n_mb = W_SLOW_OLD;
            end
            LD_FA_NEW: begin
                n_ma = {r_ain[31], r_ain};
                n_mb = W_SLOW_NEW;
            end
            default: begin
                n_ma = r_ma;
                n_mb = r_mb;
            end
        endcase
    end

    // One wrap step into plus or minus pi; only one branch can apply.
    always_comb begin
        if (r_ang < -PI_Q16) begin
            w_wrap = r_ang + TWO_PI_Q16;
        end else if (r_ang > PI_Q16) begin
            w_wrap = r_ang - TWO_PI_Q16;
        end else begin
            w_wrap = r_ang;
        end
    end

    // Wrist deadband tests the fresh velocity sample.
    assign w_dead = i_cfg.wrist_mode && (r_vnew > -DEADBAND_Q16) && (r_vnew < DEADBAND_Q16);

    // Magnitude of the current product plus the rounding half of 1000.
    assign w_pmag = r_prod[65] ? (~r_prod[39:0] + ROUND_HALF_K + 40'd1)
                               : (r_prod[39:0] + ROUND_HALF_K);

    // Quotient fix-up: the estimate is low by at most two.
    always_comb begin
        if (r_rem >= 12'd2000) begin
            w_corr = 2'd2;
        end else if (r_rem >= 12'd1000) begin
            w_corr = 2'd1;
        end else begin
            w_corr = 2'd0;
        end
    end
    assign w_qe     = r_cneg ? ~{1'b0, r_q} : {1'b0, r_q};
    assign w_addend = r_cneg ? (32'd1 - {30'b0, w_corr}) : {30'b0, w_corr};

    // Multiplier and input latch.
    always_ff @(posedge i_clk) begin
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_prod <= r_ma * r_mb;
        if (i_load) begin
            r_pos <= i_raw_position;
            r_vel <= i_raw_velocity;
            r_cur <= i_raw_current;
        end
    end

    // Operations on the product and the accumulator.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_ANG_RND: r_ang   <= f_rnd16(r_prod);
            OP_VNEW:    r_vnew  <= f_sat50(f_rnd16(r_prod));
            OP_CUR_MAG: begin
                r_x    <= w_pmag;
                r_cneg <= r_prod[65];
            end
            OP_ACC_LD:  r_acc   <= r_prod[48:0];
            OP_ACC_ADD: r_acc   <= r_acc + r_prod[48:0];
            OP_Q0:      r_q     <= r_prod[62:32];
            OP_FV:      r_fvn   <= w_dead ? 32'sd0 : f_sat50(f_rnd16(w_acc66));
            OP_WRAP:    r_angle <= f_sat50(w_wrap);
            OP_REM:     r_rem   <= r_x[11:0] - r_prod[11:0];
            OP_CNEW:    r_cnew  <= w_qe + w_addend;
            OP_AIN:     r_ain   <= f_sat50(r_prod[49:0]);
            default: begin
            end
        endcase
    end

    // Filter state commits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_fc <= '0;
            r_fa <= '0;
        end else begin
            case (i_ctl.op)
                OP_FC:   r_fc <= f_sat50(f_rnd16(w_acc66));
                OP_FA:   r_fa <= f_sat50(f_rnd16(w_acc66));
                OP_DONE: r_fv <= r_fvn;
                default: begin
                end
            endcase
        end
    end

    assign o_angle = r_angle;
    assign o_speed = r_fvn;
    assign o_amps  = r_fc;
    assign o_accel = r_fa;

endmodule

@@ sv/joint_feedback_filter_top.sv @@
// An accepted input beat runs through the 24-step microprogram that takes
// every product through one shared 33x33 multiplier; no new beat is
// accepted until the last step has run. The final step waits while a
// result is held stalled.
// Reset (i_rst_n low, synchronous): sequencer idle, no output beat,
// registers at their defaults, filtered velocity, current and accel zero.

module joint_feedback_filter_top import jff_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_raw_position,
    input  logic signed [31:0]   i_raw_velocity,
    input  logic signed [15:0]   i_raw_current,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_angle,
    output logic signed [31:0]   o_speed,
    output logic signed [31:0]   o_amps,
    output logic signed [31:0]   o_accel
);

    t_cfg               r_cfg;
    t_ctl               w_ctl;
    logic               w_idle;
    logic               w_in_accept;
    logic               w_out_free;
    logic               r_out_valid;
    logic signed [31:0] r_angle;
    logic signed [31:0] r_speed;
    logic signed [31:0] r_amps;
    logic signed [31:0] r_accel;
    logic signed [31:0] w_angle;
    logic signed [31:0] w_speed;
    logic signed [31:0] w_amps;
    logic signed [31:0] w_accel;

    // Handshake: a new beat only while the sequencer is idle.
    assign o_stall     = !w_idle;
    assign w_in_accept = i_valid && w_idle;
    assign w_out_free  = !r_out_valid || !i_stall;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_count    <= 32'd0;
            r_cfg.direction     <= 1'b0;
            r_cfg.pos_scale     <= 32'd411775;
            r_cfg.vel_scale     <= 32'd411775;
            r_cfg.rated_current <= 24'd65536;
            r_cfg.control_rate  <= 8'd100;
            r_cfg.wrist_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ZERO_COUNT:    r_cfg.zero_count    <= i_cfg_data;
                REG_DIRECTION:     r_cfg.direction     <= i_cfg_data[0];
                REG_POS_SCALE:     r_cfg.pos_scale     <= i_cfg_data;
                REG_VEL_SCALE:     r_cfg.vel_scale     <= i_cfg_data;
                REG_RATED_CURRENT: r_cfg.rated_current <= i_cfg_data[23:0];
                REG_CONTROL_RATE:  r_cfg.control_rate  <= i_cfg_data[7:0];
                REG_WRIST_MODE:    r_cfg.wrist_mode    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    jff_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_out_free  (w_out_free),
        .o_idle      (w_idle),
        .o_ctl       (w_ctl)
    );

    jff_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_cfg          (r_cfg),
        .i_load         (w_in_accept),
        .i_raw_position (i_raw_position),
        .i_raw_velocity (i_raw_velocity),
        .i_raw_current  (i_raw_current),
        .o_angle        (w_angle),
        .o_speed        (w_speed),
        .o_amps         (w_amps),
        .o_accel        (w_accel)
    );

    // Output register: loaded by the last step, so the next beat can start
    // while this result still waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.op == OP_DONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.op == OP_DONE) begin
            r_angle <= w_angle;
            r_speed <= w_speed;
            r_amps  <= w_amps;
            r_accel <= w_accel;
        end
    end

    assign o_valid = r_out_valid;
    assign o_angle = r_angle;
    assign o_speed = r_speed;
    assign o_amps  = r_amps;
    assign o_accel = r_accel;

`ifndef ASSERT_OFF
    // An accepted beat moves the sequencer off the idle step.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_stall)
        else $error("sequencer stayed idle after an accepted beat");

    // A held result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> (w_ctl.op != OP_DONE))
        else $error("result overwritten while stalled");

    // A result appears only from the final microprogram step.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_ctl.op == OP_DONE))
        else $error("output beat without a finished step");
`endif

endmodule
